/* rtl/kdpq_pkg.sv */
// ----------------------------------------------------------------------------
// kdpq_pkg: shared types and constants
// Sizes, action and status codes, and the records passed along the cell chain.
// ----------------------------------------------------------------------------
package kdpq_pkg;

    localparam int CAPACITY      = 64;
    localparam int KEY_BITS      = 32;
    localparam int PRIORITY_BITS = 32;
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    // stream payload layout
    localparam int ACTION_W  = 3;
    localparam int KEY_W     = 32;
    localparam int PRI_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 7;
    localparam int S_KEY_LO  = ACTION_W;
    localparam int S_PRI_LO  = S_KEY_LO + KEY_W;
    localparam int S_DATA_W  = ((S_PRI_LO + PRI_W + 7) / 8) * 8;
    localparam int M_KEY_LO  = STATUS_W;
    localparam int M_PRI_LO  = M_KEY_LO + KEY_W;
    localparam int M_OCC_LO  = M_PRI_LO + PRI_W;
    localparam int M_USED_W  = M_OCC_LO + OCC_W;
    localparam int M_DATA_W  = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 3'd0,
        ACT_REMOVE  = 3'd1,
        ACT_GET     = 3'd2,
        ACT_SET     = 3'd3,
        ACT_POP_MIN = 3'd4,
        ACT_POP_MAX = 3'd5
    } act_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EXISTS  = 3'd1,
        ST_MISSING = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAVE,
        S_BUBBLE,
        S_APPEND,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]      key;
        logic [PRIORITY_BITS-1:0] pri;
    } entry_t;

    // search token walking the chain, one cell per cycle
    typedef struct packed {
        logic                live;
        act_t                mode;
        logic [KEY_BITS-1:0] key;
        logic                have;
        entry_t              best;
    } wave_t;

    // broadcast controls from the sequencer
    typedef struct packed {
        logic   mark;
        logic   append;
        entry_t req;
    } ctl_t;

endpackage

/* rtl/keyed_double_ended_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// keyed_double_ended_priority_queue_unit: keyed min/max priority queue
// Entries sit in a chain of cells in age order; a search token sweeps the
// chain, and removals close the gap by shifting a hole toward the top.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload (low bit up)
//  s       | in  | s_tvalid/s_tready  | action[3], key[32], priority_req[32], pad
//  m       | out | m_tvalid/m_tready  | status[3], found_key[32],
//          |     |                    | found_priority[32], occupancy[7], pad
//
//  Every known action sends a search token through all CAPACITY cells.
//  Remove, set and pop then shift a hole up the chain, one cell per cycle;
//  insert and set then append the new entry as the newest cell.
//  Unused action codes skip the search. One item is in work at a time.
//  Reset clears every cell's valid bit at once; no clearing pass follows.
//  A result waiting on m_tready blocks completion, not input acceptance.
// ----------------------------------------------------------------------------
module keyed_double_ended_priority_queue_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action, key, priority_req, zero pad
    input  logic [kdpq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, found_key, found_priority, occupancy, zero pad
    output logic [kdpq_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int C = kdpq_pkg::CAPACITY;

    kdpq_pkg::state_t  state_reg, state_next;
    kdpq_pkg::act_t    act_reg, act_next;
    kdpq_pkg::entry_t  req_reg, req_next;
    kdpq_pkg::status_t st_reg, st_next;
    kdpq_pkg::entry_t  found_reg, found_next;
    logic [kdpq_pkg::CNT_W-1:0] count_reg, count_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [kdpq_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    kdpq_pkg::ctl_t    ctl;
    kdpq_pkg::wave_t   launch;
    kdpq_pkg::wave_t   wave_q [C];
    kdpq_pkg::entry_t  cell_data [C];
    logic [C-1:0]      cell_valid;
    logic [C-1:0]      cell_hole;

    logic              accept;
    logic [kdpq_pkg::ACTION_W-1:0] s_action;
    kdpq_pkg::wave_t   wave_end;

    assign s_action = s_tdata[kdpq_pkg::ACTION_W-1:0];
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == kdpq_pkg::S_IDLE);
    assign wave_end = wave_q[C-1];

    // token enters cell 0 in the accept cycle
    always_comb
    begin
        launch      = '0;
        launch.live = accept && (s_action <= kdpq_pkg::ACTION_W'(kdpq_pkg::ACT_POP_MAX));
        launch.mode = kdpq_pkg::act_t'(s_action);
        launch.key  = s_tdata[kdpq_pkg::S_KEY_LO +: kdpq_pkg::KEY_BITS];
    end

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        req_next      = req_reg;
        st_next       = st_reg;
        found_next    = found_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ctl           = '0;
        ctl.req       = req_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            kdpq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    act_next    = kdpq_pkg::act_t'(s_action);
                    req_next.key = s_tdata[kdpq_pkg::S_KEY_LO +: kdpq_pkg::KEY_BITS];
                    req_next.pri = s_tdata[kdpq_pkg::S_PRI_LO +: kdpq_pkg::PRIORITY_BITS];
                    st_next     = kdpq_pkg::ST_OK;
                    found_next  = '0;
                    state_next  = launch.live ? kdpq_pkg::S_WAVE : kdpq_pkg::S_RESULT;
                end
            end
            kdpq_pkg::S_WAVE:
            begin
                if (wave_end.live)
                begin
                    state_next = kdpq_pkg::S_RESULT;
                    unique case (act_reg)
                        kdpq_pkg::ACT_INSERT:
                        begin
                            if (wave_end.have)
                            begin
                                st_next = kdpq_pkg::ST_EXISTS;
                            end
                            else if (count_reg == kdpq_pkg::CNT_W'(C))
                            begin
                                st_next = kdpq_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                state_next = kdpq_pkg::S_APPEND;
                            end
                        end
                        kdpq_pkg::ACT_REMOVE, kdpq_pkg::ACT_SET:
                        begin
                            if (!wave_end.have)
                            begin
                                st_next = kdpq_pkg::ST_MISSING;
                            end
                            else
                            begin
                                ctl.mark   = 1'b1;
                                state_next = kdpq_pkg::S_BUBBLE;
                                if (act_reg == kdpq_pkg::ACT_REMOVE)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        kdpq_pkg::ACT_GET:
                        begin
                            if (!wave_end.have)
                            begin
                                st_next = kdpq_pkg::ST_MISSING;
                            end
                            else
                            begin
                                found_next.pri = wave_end.best.pri;
                            end
                        end
                        default:
                        begin
                            // pop min or pop max: drop the winner by its key
                            if (!wave_end.have)
                            begin
                                st_next = kdpq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                found_next  = wave_end.best;
                                ctl.mark    = 1'b1;
                                ctl.req.key = wave_end.best.key;
                                count_next  = count_reg - 1'b1;
                                state_next  = kdpq_pkg::S_BUBBLE;
                            end
                        end
                    endcase
                end
            end
            kdpq_pkg::S_BUBBLE:
            begin
                if (cell_hole == '0)
                begin
                    state_next = (act_reg == kdpq_pkg::ACT_SET) ? kdpq_pkg::S_APPEND
                                                                : kdpq_pkg::S_RESULT;
                end
            end
            kdpq_pkg::S_APPEND:
            begin
                ctl.append = 1'b1;
                state_next = kdpq_pkg::S_RESULT;
            end
            kdpq_pkg::S_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[kdpq_pkg::STATUS_W-1:0] = st_reg;
                    m_tdata_next[kdpq_pkg::M_KEY_LO +: kdpq_pkg::KEY_W] =
                        kdpq_pkg::KEY_W'(found_reg.key);
                    m_tdata_next[kdpq_pkg::M_PRI_LO +: kdpq_pkg::PRI_W] =
                        kdpq_pkg::PRI_W'(found_reg.pri);
                    m_tdata_next[kdpq_pkg::M_OCC_LO +: kdpq_pkg::OCC_W] =
                        kdpq_pkg::OCC_W'(count_reg);
                    state_next = kdpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kdpq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kdpq_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        req_reg     <= req_next;
        st_reg      <= st_next;
        found_reg   <= found_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // cell chain: cell 0 holds the oldest entry
    for (genvar i = 0; i < C; i++)
    begin : g_cell
        logic             nv;
        kdpq_pkg::entry_t nd;
        logic             pv;
        logic             ph;
        kdpq_pkg::wave_t  wi;
        if (i == C - 1)
        begin : g_top
            assign nv = 1'b0;
            assign nd = '0;
        end
        else
        begin : g_mid
            assign nv = cell_valid[i+1];
            assign nd = cell_data[i+1];
        end
        if (i == 0)
        begin : g_bot
            assign pv = 1'b1;
            assign ph = 1'b0;
            assign wi = launch;
        end
        else
        begin : g_up
            assign pv = cell_valid[i-1];
            assign ph = cell_hole[i-1];
            assign wi = wave_q[i-1];
        end
        kdpq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .nxt_valid(nv),
            .nxt_data (nd),
            .prv_valid(pv),
            .prv_hole (ph),
            .wave_in  (wi),
            .valid    (cell_valid[i]),
            .hole     (cell_hole[i]),
            .data     (cell_data[i]),
            .wave_out (wave_q[i])
        );
    end

    // at most one removal hole in flight
    a_one_hole: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_hole))
        else $error("more than one hole in chain");

    // occupied cells stay packed from cell 0 and match the count
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid & (cell_valid + 1'b1)) == '0))
        else $error("gap in occupied cells");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kdpq_pkg::S_IDLE) |-> ($countones(cell_valid) == int'(count_reg)))
        else $error("count disagrees with cells");

    // no input is taken while a hole is moving
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (cell_hole == '0))
        else $error("ready during shift");

endmodule

/* rtl/kdpq_cell.sv */
// ----------------------------------------------------------------------------
// kdpq_cell: one slot of the age-ordered entry chain
// Holds one entry, passes the search token on, and shifts a removal hole up.
// ----------------------------------------------------------------------------
module kdpq_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  kdpq_pkg::ctl_t   ctl,
    input  logic             nxt_valid,
    input  kdpq_pkg::entry_t nxt_data,
    input  logic             prv_valid,
    input  logic             prv_hole,
    input  kdpq_pkg::wave_t  wave_in,
    output logic             valid,
    output logic             hole,
    output kdpq_pkg::entry_t data,
    output kdpq_pkg::wave_t  wave_out
);

    logic             valid_reg, valid_next;
    logic             hole_reg, hole_next;
    kdpq_pkg::entry_t data_reg, data_next;
    kdpq_pkg::wave_t  wave_reg, wave_next;
    logic             hit;

    always_comb
    begin
        valid_next = valid_reg;
        hole_next  = hole_reg;
        data_next  = data_reg;
        if (ctl.mark && valid_reg && data_reg.key == ctl.req.key)
        begin
            hole_next = 1'b1;
        end
        // hole takes the upper neighbor, or dies at the last occupied cell
        if (hole_reg)
        begin
            if (nxt_valid)
            begin
                data_next = nxt_data;
            end
            else
            begin
                valid_next = 1'b0;
            end
            hole_next = 1'b0;
        end
        if (prv_hole && valid_reg)
        begin
            hole_next = 1'b1;
        end
        if (ctl.append && !valid_reg && prv_valid)
        begin
            valid_next = 1'b1;
            data_next  = ctl.req;
        end

        hit = 1'b0;
        if (wave_in.live && valid_reg)
        begin
            unique case (wave_in.mode)
                kdpq_pkg::ACT_POP_MIN: hit = !wave_in.have || data_reg.pri <= wave_in.best.pri;
                kdpq_pkg::ACT_POP_MAX: hit = !wave_in.have || data_reg.pri > wave_in.best.pri;
                default:               hit = data_reg.key == wave_in.key;
            endcase
        end
        wave_next = wave_in;
        if (hit)
        begin
            wave_next.have = 1'b1;
            wave_next.best = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hole_reg  <= 1'b0;
            wave_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            hole_reg  <= hole_next;
            wave_reg  <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid    = valid_reg;
    assign hole     = hole_reg;
    assign data     = data_reg;
    assign wave_out = wave_reg;

endmodule

/* dv/tb_keyed_double_ended_priority_queue_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_double_ended_priority_queue_unit: self-checking stream testbench
// A local age-ordered queue model predicts every response. Random valid and
// ready idling, a long stretch without idling and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_keyed_double_ended_priority_queue_unit;
    import kdpq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 3 * CAPACITY;
    localparam int RANDOM_ITEMS   = 1850;

    // last member sits in the lowest bits, matching the stream layout
    typedef struct packed {
        logic [31:0] pri;
        logic [31:0] key;
        logic [2:0]  action;
    } req_t;

    typedef struct packed {
        logic [OCC_W-1:0]    occ;
        logic [31:0]         pri;
        logic [31:0]         key;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // model state: slots 0..held-1, oldest first
    logic [31:0] mdl_key [CAPACITY];
    logic [31:0] mdl_pri [CAPACITY];
    int          mdl_held;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors;
    bit   calm;          // no idling on either side
    int   holdoff;       // receiver hold-off cycles left
    int   idle_cycles;

    keyed_double_ended_priority_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int find_key(logic [31:0] k);
        for (int i = 0; i < mdl_held; i++)
            if (mdl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void drop_at(int s);
        for (int i = s; i + 1 < mdl_held; i++)
        begin
            mdl_key[i] = mdl_key[i + 1];
            mdl_pri[i] = mdl_pri[i + 1];
        end
        mdl_held--;
    endfunction

    function automatic void add_newest(logic [31:0] k, logic [31:0] p);
        mdl_key[mdl_held] = k;
        mdl_pri[mdl_held] = p;
        mdl_held++;
    endfunction

    // apply one request to the model and return the expected response
    function automatic rsp_t apply_queue_op(req_t r);
        rsp_t o;
        int   s;
        int   best;
        o = '0;
        o.status = ST_OK;
        case (r.action)
            ACT_INSERT:
                if (find_key(r.key) >= 0)
                    o.status = ST_EXISTS;
                else if (mdl_held >= CAPACITY)
                    o.status = ST_FULL;
                else
                    add_newest(r.key, r.pri);
            ACT_REMOVE, ACT_GET, ACT_SET:
            begin
                s = find_key(r.key);
                if (s < 0)
                    o.status = ST_MISSING;
                else if (r.action == ACT_GET)
                    o.pri = mdl_pri[s];
                else
                begin
                    drop_at(s);
                    if (r.action == ACT_SET)
                        add_newest(r.key, r.pri);
                end
            end
            ACT_POP_MIN, ACT_POP_MAX:
                if (mdl_held == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    best = 0;
                    for (int i = 1; i < mdl_held; i++)
                        if (r.action == ACT_POP_MIN ? mdl_pri[i] <= mdl_pri[best]
                                                    : mdl_pri[i] > mdl_pri[best])
                            best = i;
                    o.key = mdl_key[best];
                    o.pri = mdl_pri[best];
                    drop_at(best);
                end
            default: ;
        endcase
        o.occ = mdl_held[OCC_W-1:0];
        return o;
    endfunction

    // keys from a small pool so hits and duplicates are common
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 95);
        endcase
    endfunction

    function automatic logic [31:0] pick_pri();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h0;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 15);   // many ties
        endcase
    endfunction

    function automatic req_t mk(logic [2:0] a, logic [31:0] k, logic [31:0] p);
        req_t r;
        r.action = a;
        r.key    = k;
        r.pri    = p;
        return r;
    endfunction

    // driver: one nonblocking write per signal per edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 36))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_W'(pending_reqs.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // predictor runs on accepted items
    always @(posedge clk)
        if (rst_n && s_tvalid && s_tready)
            expected_rsps.push_back(apply_queue_op(req_t'(s_tdata[S_PRI_LO+PRI_W-1:0])));

    // receiver ready with idling and a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (holdoff > 0)
        begin
            holdoff  <= holdoff - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || $urandom_range(0, 99) >= 36;
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = rsp_t'(m_tdata[M_USED_W-1:0]);
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected response, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                if (got.key !== want.key)
                    $display("%0t: found_key expected %h actual %h", $time, want.key, got.key);
                if (got.pri !== want.pri)
                    $display("%0t: found_priority expected %h actual %h", $time, want.pri,
                             got.pri);
                if (got.occ !== want.occ)
                    $display("%0t: occupancy expected %0d actual %0d", $time, want.occ,
                             got.occ);
                if (got !== want)
                    errors++;
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        errors = 0;
        calm = 0;
        holdoff = 0;
        idle_cycles = 0;
        mdl_held = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pops, missing keys, extremes, ties, unused codes
        pending_reqs.push_back(mk(ACT_POP_MIN, 0, 0));
        pending_reqs.push_back(mk(ACT_POP_MAX, 0, 0));
        pending_reqs.push_back(mk(ACT_REMOVE, 5, 0));
        pending_reqs.push_back(mk(ACT_GET, 5, 0));
        pending_reqs.push_back(mk(ACT_SET, 5, 9));
        pending_reqs.push_back(mk(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk(ACT_INSERT, 0, 0));
        pending_reqs.push_back(mk(ACT_INSERT, 7, 32'h5555_AAAA));
        pending_reqs.push_back(mk(ACT_INSERT, 8, 32'h5555_AAAA));
        pending_reqs.push_back(mk(ACT_INSERT, 9, 0));
        pending_reqs.push_back(mk(ACT_INSERT, 7, 1));
        pending_reqs.push_back(mk(ACT_GET, 32'hFFFF_FFFF, 0));
        pending_reqs.push_back(mk(ACT_SET, 0, 32'hAAAA_5555));
        pending_reqs.push_back(mk(3'd6, 32'h1234_5678, 32'h9ABC_DEF0));
        pending_reqs.push_back(mk(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk(ACT_POP_MIN, 0, 0));      // key 9, the only zero priority left after the set
        pending_reqs.push_back(mk(ACT_POP_MAX, 0, 0));
        pending_reqs.push_back(mk(ACT_POP_MAX, 0, 0));
        pending_reqs.push_back(mk(ACT_REMOVE, 8, 0));
        pending_reqs.push_back(mk(ACT_POP_MIN, 0, 0));
        pending_reqs.push_back(mk(ACT_POP_MIN, 0, 0));

        // fill to full, then duplicate and overflow on full store
        for (int i = 0; i < CAPACITY; i++)
            pending_reqs.push_back(mk(ACT_INSERT, 32'(1000 + i), $urandom_range(0, 7)));
        pending_reqs.push_back(mk(ACT_INSERT, 1003, 1));
        pending_reqs.push_back(mk(ACT_INSERT, 1, 1));

        // random: mostly well-formed mixes over a small key pool
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            int roll;
            roll = $urandom_range(0, 99);
            if (roll < 35)
                pending_reqs.push_back(mk(ACT_INSERT, pick_key(), pick_pri()));
            else if (roll < 45)
                pending_reqs.push_back(mk(ACT_REMOVE, pick_key(), $urandom));
            else if (roll < 55)
                pending_reqs.push_back(mk(ACT_GET, pick_key(), $urandom));
            else if (roll < 67)
                pending_reqs.push_back(mk(ACT_SET, pick_key(), pick_pri()));
            else if (roll < 82)
                pending_reqs.push_back(mk(ACT_POP_MIN, $urandom, $urandom));
            else if (roll < 97)
                pending_reqs.push_back(mk(ACT_POP_MAX, $urandom, $urandom));
            else
                pending_reqs.push_back(mk(3'($urandom_range(6, 7)), $urandom, $urandom));
        end

        // long hold-off after a while, then a stretch without idling
        wait (pending_reqs.size() < RANDOM_ITEMS - 200);
        @(posedge clk);
        holdoff <= 3000;
        wait (pending_reqs.size() < RANDOM_ITEMS - 900);
        @(posedge clk);
        calm <= 1'b1;
        wait (pending_reqs.size() < RANDOM_ITEMS - 1300);
        @(posedge clk);
        calm <= 1'b0;

        wait (pending_reqs.size() == 0);
        @(posedge clk);
        wait (!s_tvalid);
        wait (expected_rsps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_rsps.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
